// ===== src/bpu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Branch predictor shared definitions
// Request codes, counter constants and the target buffer handshake types.
// ----------------------------------------------------------------------------
package bpu_pkg;

    localparam logic OP_PREDICT = 1'b0;
    localparam logic OP_UPDATE  = 1'b1;

    localparam logic [1:0] KIND_COND = 2'd0;
    localparam logic [1:0] KIND_CALL = 2'd1;
    localparam logic [1:0] KIND_RET  = 2'd2;

    localparam logic [1:0] CTR_RESET     = 2'd1;
    localparam logic [1:0] CTR_TAKEN_MIN = 2'd2;
    localparam logic [1:0] CTR_MAX       = 2'd3;
    localparam logic [1:0] CTR_MIN       = 2'd0;

    typedef struct packed {
        logic        start;
        logic        update;
        logic [31:0] addr;
        logic [31:0] target;
    } t_btb_req;

    typedef struct packed {
        logic        done;
        logic        hit;
        logic [31:0] target;
    } t_btb_rsp;

endpackage

// ===== src/bpu_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Branch predictor request channel
// Carries one predict or update word with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bpu_req_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [1:0]  branch_kind;
    logic [31:0] branch_addr;
    logic [31:0] next_addr;
    logic        taken;
    logic [31:0] actual_target;

    modport source (
        output valid, op, branch_kind, branch_addr, next_addr, taken, actual_target,
        input  ready
    );
    modport sink (
        input  valid, op, branch_kind, branch_addr, next_addr, taken, actual_target,
        output ready
    );
endinterface

// ===== src/bpu_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Branch predictor response channel
// Carries one prediction word with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bpu_rsp_if;
    logic        valid;
    logic        ready;
    logic        predicted_taken;
    logic [31:0] predicted_target;

    modport source (
        output valid, predicted_taken, predicted_target,
        input  ready
    );
    modport sink (
        input  valid, predicted_taken, predicted_target,
        output ready
    );
endinterface

// ===== src/bpu_pht.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pattern history table
// Two-bit counter memory with a registered read and a clearing pass after reset.
// ----------------------------------------------------------------------------
module bpu_pht #(
    parameter int HISTORY_BITS = 10
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_rd_en,
    input  logic [HISTORY_BITS-1:0] i_rd_idx,
    input  logic                    i_wr_en,
    input  logic [HISTORY_BITS-1:0] i_wr_idx,
    input  logic [1:0]              i_wr_data,
    output logic [1:0]              o_rd_data,
    output logic                    o_ready
);
    import bpu_pkg::*;

    localparam int DEPTH = 1 << HISTORY_BITS;

    logic [1:0]              r_mem [DEPTH];
    logic [1:0]              r_rd_data;
    logic                    r_clr;
    logic [HISTORY_BITS-1:0] r_clr_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= 1'b1;
            r_clr_idx <= '0;
        end else if (r_clr) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == {HISTORY_BITS{1'b1}}) begin
                r_clr <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr) begin
            r_mem[r_clr_idx] <= CTR_RESET;
        end else if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_idx];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_ready   = !r_clr;

endmodule

// ===== src/bpu_btb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Branch target buffer
// Fully associative FIFO-replaced buffer held in one memory and searched one
// entry per cycle, oldest first.
// ----------------------------------------------------------------------------
module bpu_btb #(
    parameter int BTB_ENTRIES = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bpu_pkg::t_btb_req  i_req,
    output bpu_pkg::t_btb_rsp  o_rsp
);
    import bpu_pkg::*;

    localparam int BI = (BTB_ENTRIES > 1) ? $clog2(BTB_ENTRIES) : 1;
    localparam int CW = $clog2(BTB_ENTRIES + 1);

    typedef enum logic {B_IDLE, B_SEARCH} t_state;

    t_state         r_state;
    logic [63:0]    r_mem [BTB_ENTRIES];
    logic [63:0]    r_rd_data;
    logic [BI-1:0]  r_rd_slot;
    logic           r_pend;
    logic [CW-1:0]  r_i;
    logic [CW-1:0]  r_fill;
    logic [BI-1:0]  r_oldest;

    logic           w_hit;
    logic           w_done;
    logic           w_full;
    logic [BI:0]    w_sum;
    logic [BI-1:0]  w_slot;
    logic [BI:0]    w_app_sum;
    logic [BI-1:0]  w_app_slot;
    logic [BI-1:0]  w_oldest_inc;
    logic [BI-1:0]  w_wr_slot;

    always_comb begin
        w_sum = {1'b0, r_oldest} + (BI+1)'(r_i);
        if (w_sum >= (BI+1)'(BTB_ENTRIES)) begin
            w_slot = BI'(w_sum - (BI+1)'(BTB_ENTRIES));
        end else begin
            w_slot = BI'(w_sum);
        end
        w_app_sum = {1'b0, r_oldest} + (BI+1)'(r_fill);
        if (w_app_sum >= (BI+1)'(BTB_ENTRIES)) begin
            w_app_slot = BI'(w_app_sum - (BI+1)'(BTB_ENTRIES));
        end else begin
            w_app_slot = BI'(w_app_sum);
        end
        if (r_oldest == BI'(BTB_ENTRIES - 1)) begin
            w_oldest_inc = '0;
        end else begin
            w_oldest_inc = r_oldest + 1'b1;
        end
        w_full = (r_fill == CW'(BTB_ENTRIES));
        w_hit  = r_pend && (r_rd_data[63:32] == i_req.addr);
        w_done = (r_state == B_SEARCH) && (w_hit || r_i >= r_fill);
        if (w_hit) begin
            w_wr_slot = r_rd_slot;
        end else if (w_full) begin
            w_wr_slot = r_oldest;
        end else begin
            w_wr_slot = w_app_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_pend   <= 1'b0;
            r_i      <= '0;
            r_fill   <= '0;
            r_oldest <= '0;
        end else begin
            unique case (r_state)
                B_IDLE: begin
                    if (i_req.start) begin
                        r_i     <= '0;
                        r_pend  <= 1'b0;
                        r_state <= B_SEARCH;
                    end
                end
                B_SEARCH: begin
                    if (w_done) begin
                        r_pend  <= 1'b0;
                        r_state <= B_IDLE;
                        if (i_req.update && !w_hit) begin
                            if (w_full) begin
                                r_oldest <= w_oldest_inc;
                            end else begin
                                r_fill <= r_fill + 1'b1;
                            end
                        end
                    end else begin
                        r_pend    <= 1'b1;
                        r_i       <= r_i + 1'b1;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == B_SEARCH && !w_done) begin
            r_rd_data <= r_mem[w_slot];
            r_rd_slot <= w_slot;
        end
        if (w_done && i_req.update) begin
            r_mem[w_wr_slot] <= {i_req.addr, i_req.target};
        end
    end

    assign o_rsp.done   = w_done;
    assign o_rsp.hit    = w_hit;
    assign o_rsp.target = r_rd_data[31:0];

endmodule

// ===== src/gshare_btb_ras_branch_predictor_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gshare branch predictor with target buffer and return stack
// Takes predict and update words and returns one prediction per predict.
// ----------------------------------------------------------------------------
// After reset the block clears its 2^HISTORY_BITS counters, one per cycle, and
// takes no word until that pass is over.
// One word is worked on at a time. A not-taken conditional predict or a
// return skips the target buffer; a call, a taken conditional predict or an
// update searches it, one entry after another, because the buffer tags are
// read through a single memory port, oldest entry first.
// A finished prediction waits in an output register while the next word is
// taken in.
module gshare_btb_ras_branch_predictor_unit #(
    parameter int HISTORY_BITS = 10,
    parameter int BTB_ENTRIES  = 64,
    parameter int RAS_DEPTH    = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bpu_req_if.sink    i_req,
    bpu_rsp_if.source  o_rsp
);
    import bpu_pkg::*;

    localparam int RI = (RAS_DEPTH > 1) ? $clog2(RAS_DEPTH) : 1;
    localparam int RC = $clog2(RAS_DEPTH + 1);

    typedef enum logic [1:0] {S_IDLE, S_PHT, S_BTB, S_OUT} t_state;

    t_state                  r_state;
    logic                    r_op;
    logic [1:0]              r_kind;
    logic [31:0]             r_addr;
    logic                    r_taken;
    logic [31:0]             r_actual;
    logic [HISTORY_BITS-1:0] r_idx;
    logic [HISTORY_BITS-1:0] r_hist;
    logic                    r_ret_hit;
    logic [RI-1:0]           r_ras_top;
    logic [RC-1:0]           r_ras_cnt;
    logic [31:0]             r_ras [RAS_DEPTH];
    logic [31:0]             r_ras_rd;
    logic                    r_res_taken;
    logic [31:0]             r_res_target;
    logic                    r_out_valid;
    logic                    r_out_taken;
    logic [31:0]             r_out_target;

    logic                    w_accept;
    logic                    w_pht_ready;
    logic [1:0]              w_pht_rd;
    logic [HISTORY_BITS-1:0] w_idx;
    logic [1:0]              w_trained;
    logic                    w_pht_wr;
    logic [RI-1:0]           w_top_inc;
    logic [RI-1:0]           w_top_dec;
    logic                    w_push;
    logic                    w_pop;
    logic                    w_load_out;
    t_btb_req                w_btb_req;
    t_btb_rsp                w_btb_rsp;

    assign w_idx    = i_req.branch_addr[HISTORY_BITS-1:0] ^ r_hist;
    assign w_accept = i_req.valid && i_req.ready;
    assign w_push   = w_accept && i_req.op == OP_PREDICT && i_req.branch_kind == KIND_CALL;
    assign w_pop    = w_accept && i_req.op == OP_PREDICT && i_req.branch_kind == KIND_RET
                      && r_ras_cnt != '0;
    assign w_pht_wr = (r_state == S_PHT) && r_op == OP_UPDATE;
    assign w_load_out = (r_state == S_OUT) && (!r_out_valid || o_rsp.ready);

    always_comb begin
        if (r_ras_top == RI'(RAS_DEPTH - 1)) begin
            w_top_inc = '0;
        end else begin
            w_top_inc = r_ras_top + 1'b1;
        end
        if (r_ras_top == '0) begin
            w_top_dec = RI'(RAS_DEPTH - 1);
        end else begin
            w_top_dec = r_ras_top - 1'b1;
        end
        if (r_taken) begin
            w_trained = (w_pht_rd == CTR_MAX) ? w_pht_rd : w_pht_rd + 1'b1;
        end else begin
            w_trained = (w_pht_rd == CTR_MIN) ? w_pht_rd : w_pht_rd - 1'b1;
        end
        w_btb_req.start  = (r_state == S_PHT)
                           && (r_op == OP_UPDATE || r_kind == KIND_CALL
                               || (r_kind != KIND_RET && w_pht_rd >= CTR_TAKEN_MIN));
        w_btb_req.update = (r_op == OP_UPDATE);
        w_btb_req.addr   = r_addr;
        w_btb_req.target = r_actual;
    end

    bpu_pht #(
        .HISTORY_BITS (HISTORY_BITS)
    ) u_pht (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_accept),
        .i_rd_idx  (w_idx),
        .i_wr_en   (w_pht_wr),
        .i_wr_idx  (r_idx),
        .i_wr_data (w_trained),
        .o_rd_data (w_pht_rd),
        .o_ready   (w_pht_ready)
    );

    bpu_btb #(
        .BTB_ENTRIES (BTB_ENTRIES)
    ) u_btb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_btb_req),
        .o_rsp   (w_btb_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_ras[w_top_inc] <= i_req.next_addr;
        end
        if (w_pop) begin
            r_ras_rd <= r_ras[r_ras_top];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hist      <= '0;
            r_ras_top   <= '0;
            r_ras_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op      <= i_req.op;
                        r_kind    <= i_req.branch_kind;
                        r_addr    <= i_req.branch_addr;
                        r_taken   <= i_req.taken;
                        r_actual  <= i_req.actual_target;
                        r_idx     <= w_idx;
                        r_ret_hit <= w_pop;
                        if (i_req.op == OP_UPDATE) begin
                            r_hist <= {r_hist[HISTORY_BITS-2:0], i_req.taken};
                        end
                        if (w_push) begin
                            r_ras_top <= w_top_inc;
                            if (r_ras_cnt != RC'(RAS_DEPTH)) begin
                                r_ras_cnt <= r_ras_cnt + 1'b1;
                            end
                        end
                        if (w_pop) begin
                            r_ras_top <= w_top_dec;
                            r_ras_cnt <= r_ras_cnt - 1'b1;
                        end
                        r_state <= S_PHT;
                    end
                end
                S_PHT: begin
                    if (w_btb_req.start) begin
                        r_state <= S_BTB;
                    end else begin
                        r_res_taken  <= (r_kind == KIND_RET);
                        r_res_target <= r_ret_hit ? r_ras_rd : r_addr;
                        r_state      <= S_OUT;
                    end
                end
                S_BTB: begin
                    if (w_btb_rsp.done) begin
                        r_res_taken  <= 1'b1;
                        r_res_target <= w_btb_rsp.hit ? w_btb_rsp.target : r_addr;
                        r_state      <= (r_op == OP_UPDATE) ? S_IDLE : S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_load_out) begin
                        r_out_taken  <= r_res_taken;
                        r_out_target <= r_res_target;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_req.ready            = (r_state == S_IDLE) && w_pht_ready;
    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.predicted_taken  = r_out_taken;
    assign o_rsp.predicted_target = r_out_target;

`ifndef ASSERT_OFF
    a_ras_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ras_cnt <= RC'(RAS_DEPTH))
        else $error("return stack count exceeds its depth");

    a_btb_done_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_btb_rsp.done |-> r_state == S_BTB)
        else $error("target buffer finished outside a search");

    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out |=> (r_out_valid && r_state == S_IDLE))
        else $error("prediction not presented after completion");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_pht_ready |-> !w_accept)
        else $error("word accepted during counter clearing");
`endif

endmodule
